// File: rtl/mqr_pkg.sv
// Shared constants, types and helper functions of the multi-queue rebalancer.
package mqr_pkg;

   localparam int NUM_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 64;
   localparam int ID_BITS     = 16;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
   localparam int TW = LW + 16;

   localparam logic [1:0] OP_ARRIVE = 2'd0;
   localparam logic [1:0] OP_REBAL  = 2'd1;
   localparam logic [1:0] OP_ADMIT  = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BALANCED = 3'd3;
   localparam logic [2:0] ST_LIMIT    = 3'd4;

   localparam logic [1:0] REG_QUEUE_COUNT  = 2'd0;
   localparam logic [1:0] REG_GATE_TIME    = 2'd1;
   localparam logic [1:0] REG_MAX_SWITCHES = 2'd2;

   localparam logic [63:0] LCG_MUL      = 64'd6364136223846793005;
   localparam logic [63:0] LCG_SEED     = 64'd123456789;
   localparam logic [15:0] SWITCH_RESET = 16'd10000;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] person_id;
      logic [2:0]  gate;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  source_queue;
      logic [2:0]  target_queue;
      logic [15:0] person;
      logic [21:0] wait_time;
      logic [15:0] switches_done;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [ID_BITS-1:0] id;
      logic [2:0]         q;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  queue_count;
      logic [15:0] gate_time;
      logic [15:0] max_switches;
   } cfg_type;

   function automatic logic [QW:0] active_count(input logic [3:0] qc);
      logic [QW:0] n;
      if (qc == 4'd0) n = (QW+1)'(1);
      else if (int'(qc) > NUM_QUEUES) n = (QW+1)'(NUM_QUEUES);
      else n = (QW+1)'(qc);
      return n;
   endfunction

   function automatic logic [TW-1:0] time_of(input logic [LW-1:0] len,
                                             input logic [15:0] gt);
      return TW'(len) * TW'(gt);
   endfunction

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (int'(p) + 1 >= QUEUE_DEPTH) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   function automatic logic [AW-1:0] store_addr(input logic [QW-1:0] q,
                                                input logic [PW-1:0] p);
      return AW'(int'(q) * QUEUE_DEPTH + int'(p));
   endfunction

endpackage

// File: rtl/mqr_ram.sv
// Generic single write port, single read port RAM with registered read.
module mqr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/mqr_front.sv
// Front end: takes requests, steps the LCG and picks the arrival queue.
module mqr_front import mqr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   input  cfg_type cfg,
   output logic    push,
   output cmd_type push_cmd,
   input  logic    fifo_full
);
   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_MUL0 = 3'd1;
   localparam logic [2:0] F_MUL1 = 3'd2;
   localparam logic [2:0] F_MUL2 = 3'd3;
   localparam logic [2:0] F_SUM  = 3'd4;
   localparam logic [2:0] F_MOD  = 3'd5;
   localparam logic [2:0] F_PUSH = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [63:0] lcg_ff, lcg_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] cross_ff, cross_in;
   logic [31:0] val_ff, val_in;
   logic [QW:0] rem_ff, rem_in;
   logic [2:0]  cnt_ff, cnt_in;
   cmd_type     cmd_ff, cmd_in;

   logic [63:0] mul_p;
   logic [63:0] lcg_sum;
   logic [QW:0] n;
   logic [QW:0] r;

   assign n    = active_count(cfg.queue_count);
   assign busy = (state_ff != F_IDLE);
   assign push = (state_ff == F_PUSH);
   assign push_cmd = cmd_ff;

   always_comb begin
      state_in = state_ff;
      lcg_in   = lcg_ff;
      prod_in  = prod_ff;
      cross_in = cross_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      mul_p    = '0;
      lcg_sum  = '0;
      r        = rem_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               cmd_in.op = req_data.op;
               cmd_in.id = ID_BITS'(req_data.person_id);
               cmd_in.q  = req_data.gate;
               if (req_data.op == OP_ARRIVE) state_in = F_MUL0;
               else if (req_data.op == OP_REBAL || req_data.op == OP_ADMIT)
                  state_in = F_PUSH;
            end
         end
         F_MUL0: begin
            prod_in  = lcg_ff[31:0] * LCG_MUL[31:0];
            state_in = F_MUL1;
         end
         F_MUL1: begin
            mul_p    = lcg_ff[63:32] * LCG_MUL[31:0];
            cross_in = mul_p[31:0];
            state_in = F_MUL2;
         end
         F_MUL2: begin
            mul_p    = lcg_ff[31:0] * LCG_MUL[63:32];
            cross_in = cross_ff + mul_p[31:0];
            state_in = F_SUM;
         end
         F_SUM: begin
            lcg_sum = prod_ff + {cross_ff, 32'd0} + 64'd1;
            if (&lcg_sum) lcg_sum = '0;
            lcg_in   = lcg_sum;
            val_in   = lcg_sum[63:32];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = F_MOD;
         end
         F_MOD: begin
            // four restoring remainder steps, most significant bits first
            for (int i = 0; i < 4; i++) begin
               r = {r[QW-1:0], val_ff[31-i]};
               if (r >= n) r = r - n;
            end
            rem_in = r;
            val_in = {val_ff[27:0], 4'd0};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               cmd_in.q = 3'(r[QW-1:0]);
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!fifo_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         lcg_ff   <= LCG_SEED;
      end else begin
         state_ff <= state_in;
         lcg_ff   <= lcg_in;
      end
      prod_ff  <= prod_in;
      cross_ff <= cross_in;
      val_ff   <= val_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      cmd_ff   <= cmd_in;
   end
endmodule

// File: rtl/mqr_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module mqr_cmd_fifo import mqr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_cmd
);
   cmd_type    ent_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign valid   = (cnt_ff != 2'd0);
   assign pop_cmd = ent_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         ent_ff[wr_ff] <= push_cmd;
      end
   end
endmodule

// File: rtl/mqr_back.sv
// Back end: queue bookkeeping, id store, rebalance scan and result register.
module mqr_back import mqr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   localparam logic [2:0] B_IDLE      = 3'd0;
   localparam logic [2:0] B_ARRIVE    = 3'd1;
   localparam logic [2:0] B_ADMIT     = 3'd2;
   localparam logic [2:0] B_ADMIT_OUT = 3'd3;
   localparam logic [2:0] B_REBAL     = 3'd4;
   localparam logic [2:0] B_SCAN      = 3'd5;
   localparam logic [2:0] B_DECIDE    = 3'd6;
   localparam logic [2:0] B_MOVE      = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic          move_wr_ff, move_wr_in;
   cmd_type       cmd_ff, cmd_in;
   logic [QW-1:0] cur_ff, cur_in;
   logic [PW-1:0] head_ff [NUM_QUEUES];
   logic [PW-1:0] tail_ff [NUM_QUEUES];
   logic [LW-1:0] len_ff  [NUM_QUEUES];
   logic [PW-1:0] head_in, tail_in;
   logic [LW-1:0] len_in;
   logic          qwe;
   logic [15:0]   sw_ff, sw_in;
   logic [QW-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [TW-1:0] tmax_ff, tmax_in, tmin_ff, tmin_in;
   logic [LW-1:0] len_hi_ff, len_hi_in, len_lo_ff, len_lo_in;
   logic [21:0]   wait_ff, wait_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [PW-1:0] cur_head, cur_tail;
   logic [LW-1:0] cur_len;
   logic [TW-1:0] t;
   logic [TW-1:0] gap;
   logic [QW:0]   n;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [ID_BITS-1:0] ram_wdata, ram_rdata;

   assign cur_head = head_ff[cur_ff];
   assign cur_tail = tail_ff[cur_ff];
   assign cur_len  = len_ff[cur_ff];
   assign n        = active_count(cfg.queue_count);
   assign t        = time_of(cur_len, cfg.gate_time);
   assign gap      = tmax_ff - tmin_ff;

   mqr_ram #(
      .WIDTH(ID_BITS),
      .DEPTH(NUM_QUEUES * QUEUE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      move_wr_in = 1'b0;
      cmd_in     = cmd_ff;
      cur_in     = cur_ff;
      head_in    = cur_head;
      tail_in    = cur_tail;
      len_in     = cur_len;
      qwe        = 1'b0;
      sw_in      = sw_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      tmax_in    = tmax_ff;
      tmin_in    = tmin_ff;
      len_hi_in  = len_hi_ff;
      len_lo_in  = len_lo_ff;
      wait_in    = wait_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      pop        = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = store_addr(cur_ff, cur_tail);
      ram_wdata  = cmd_ff.id;
      ram_raddr  = store_addr(cur_ff, cur_head);
      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               pop    = 1'b1;
               cmd_in = cmd;
               cur_in = QW'(cmd.q);
               case (cmd.op)
                  OP_ARRIVE: state_in = B_ARRIVE;
                  OP_ADMIT:  state_in = B_ADMIT;
                  OP_REBAL:  state_in = B_REBAL;
                  default:   state_in = B_IDLE;
               endcase
            end
         end
         B_ARRIVE: begin
            strobe_in = 1'b1;
            rsp_in    = '0;
            rsp_in.source_queue  = 3'(cur_ff);
            rsp_in.switches_done = sw_ff;
            if (int'(cur_len) >= QUEUE_DEPTH) begin
               rsp_in.status    = ST_FULL;
               rsp_in.wait_time = t[21:0];
            end else begin
               ram_we  = 1'b1;
               qwe     = 1'b1;
               tail_in = ptr_next(cur_tail);
               len_in  = cur_len + 1'b1;
               rsp_in.status    = ST_OK;
               rsp_in.person    = 16'(cmd_ff.id);
               rsp_in.wait_time = 22'(time_of(cur_len + 1'b1, cfg.gate_time));
            end
            state_in = B_IDLE;
         end
         B_ADMIT: begin
            if (int'(cmd_ff.q) >= NUM_QUEUES || cur_len == '0) begin
               strobe_in = 1'b1;
               rsp_in    = '0;
               rsp_in.status        = ST_EMPTY;
               rsp_in.source_queue  = cmd_ff.q;
               rsp_in.switches_done = sw_ff;
               state_in = B_IDLE;
            end else begin
               qwe      = 1'b1;
               head_in  = ptr_next(cur_head);
               len_in   = cur_len - 1'b1;
               wait_in  = 22'(time_of(cur_len - 1'b1, cfg.gate_time));
               state_in = B_ADMIT_OUT;
            end
         end
         B_ADMIT_OUT: begin
            strobe_in = 1'b1;
            rsp_in    = '0;
            rsp_in.status        = ST_OK;
            rsp_in.source_queue  = 3'(cur_ff);
            rsp_in.person        = 16'(ram_rdata);
            rsp_in.wait_time     = wait_ff;
            rsp_in.switches_done = sw_ff;
            state_in = B_IDLE;
         end
         B_REBAL: begin
            if (sw_ff >= cfg.max_switches) begin
               strobe_in = 1'b1;
               rsp_in    = '0;
               rsp_in.status        = ST_LIMIT;
               rsp_in.switches_done = sw_ff;
               state_in = B_IDLE;
            end else begin
               cur_in   = '0;
               state_in = B_SCAN;
            end
         end
         B_SCAN: begin
            // first longest and first shortest: strict compares keep the earliest
            if (cur_ff == '0) begin
               tmax_in = t; tmin_in = t;
               hi_in = '0; lo_in = '0;
               len_hi_in = cur_len; len_lo_in = cur_len;
            end else begin
               if (t > tmax_ff) begin
                  tmax_in = t; hi_in = cur_ff; len_hi_in = cur_len;
               end
               if (t < tmin_ff) begin
                  tmin_in = t; lo_in = cur_ff; len_lo_in = cur_len;
               end
            end
            if ({1'b0, cur_ff} == n - 1'b1) state_in = B_DECIDE;
            else cur_in = cur_ff + 1'b1;
         end
         B_DECIDE: begin
            if (gap <= TW'(cfg.gate_time) || len_hi_ff == '0 ||
                int'(len_lo_ff) >= QUEUE_DEPTH) begin
               strobe_in = 1'b1;
               rsp_in    = '0;
               rsp_in.status        = ST_BALANCED;
               rsp_in.source_queue  = 3'(hi_ff);
               rsp_in.wait_time     = tmax_ff[21:0];
               rsp_in.switches_done = sw_ff;
               state_in = B_IDLE;
            end else begin
               cur_in   = hi_ff;
               state_in = B_MOVE;
            end
         end
         B_MOVE: begin
            if (!move_wr_ff) begin
               // pop the longest queue's head; data lands next cycle
               qwe        = 1'b1;
               head_in    = ptr_next(cur_head);
               len_in     = cur_len - 1'b1;
               cur_in     = lo_ff;
               move_wr_in = 1'b1;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               qwe       = 1'b1;
               tail_in   = ptr_next(cur_tail);
               len_in    = cur_len + 1'b1;
               if (sw_ff != 16'hFFFF) sw_in = sw_ff + 16'd1;
               strobe_in = 1'b1;
               rsp_in    = '0;
               rsp_in.status        = ST_OK;
               rsp_in.source_queue  = 3'(hi_ff);
               rsp_in.target_queue  = 3'(lo_ff);
               rsp_in.person        = 16'(ram_rdata);
               rsp_in.wait_time     = 22'(time_of(cur_len + 1'b1, cfg.gate_time));
               rsp_in.switches_done = sw_in;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         move_wr_ff <= 1'b0;
         sw_ff      <= '0;
         strobe_ff  <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            len_ff[i]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         move_wr_ff <= move_wr_in;
         sw_ff      <= sw_in;
         strobe_ff  <= strobe_in;
         if (qwe) begin
            head_ff[cur_ff] <= head_in;
            tail_ff[cur_ff] <= tail_in;
            len_ff[cur_ff]  <= len_in;
         end
      end
      cmd_ff    <= cmd_in;
      cur_ff    <= cur_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      tmax_ff   <= tmax_in;
      tmin_ff   <= tmin_in;
      len_hi_ff <= len_hi_in;
      len_lo_ff <= len_lo_in;
      wait_ff   <= wait_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
endmodule

// File: rtl/multi_queue_rebalancer_top.sv
// Top level of the multi-queue rebalancer: config registers and the two halves.
//
// Eight FIFO queues of ids share one 512-entry store. A request is taken when
// start is high and busy is low; busy stays high while the front end holds it.
// An arrival passes the front end (three 32x32 partial products for the 64-bit
// LCG, one sum, a 4-bit-per-cycle remainder by the queue count) before it goes
// to the back end; admit and rebalance go there directly. The back end updates
// the queue for an arrival, and for an admit also reads the store unless the
// queue is empty. A rebalance takes the command, checks the switch limit, scans
// one queue per cycle, decides, then reads and writes the store; it stops early
// when balanced or at the limit. A two-entry command queue lets the front end
// take new requests while the back end works. Each registered result shows on
// rsp_* for one cycle with rsp_strobe and cannot be held off. Op code 3 is
// dropped with no result. Configuration is written through csr_*; the user
// must do so only while idle, as the block itself does not enforce it.
module multi_queue_rebalancer_top import mqr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   cfg_type cfg_ff;
   logic    push, fifo_full, fifo_valid, pop;
   cmd_type push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.queue_count  <= 4'd8;
         cfg_ff.gate_time    <= 16'd1;
         cfg_ff.max_switches <= SWITCH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_QUEUE_COUNT:  cfg_ff.queue_count  <= csr_wdata[3:0];
            REG_GATE_TIME:    cfg_ff.gate_time    <= csr_wdata;
            REG_MAX_SWITCHES: cfg_ff.max_switches <= csr_wdata;
            default: ;
         endcase
      end
   end

   mqr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .push      (push),
      .push_cmd  (push_cmd),
      .fifo_full (fifo_full)
   );

   mqr_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .valid    (fifo_valid),
      .pop_cmd  (pop_cmd)
   );

   mqr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (fifo_valid),
      .cmd        (pop_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );
endmodule

// File: rtl/mqr_checker.sv
// Port-level checks for the rebalancer, bound to the top level.
module mqr_checker import mqr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input req_type     req_data,
   input logic        rsp_strobe,
   input rsp_type     rsp_data
);
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("activity right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.status <= ST_LIMIT)
      else $error("bad status code");

   a_arrive_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.op == OP_ARRIVE |=> busy)
      else $error("arrival not held by front end");

   a_limit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_LIMIT |->
         rsp_data.source_queue == 3'd0 && rsp_data.person == 16'd0 &&
         rsp_data.wait_time == 22'd0)
      else $error("switch limit result carries data");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_EMPTY |->
         rsp_data.person == 16'd0 && rsp_data.wait_time == 22'd0 &&
         rsp_data.target_queue == 3'd0)
      else $error("empty result carries data");
endmodule

bind multi_queue_rebalancer_top mqr_checker u_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the multi-queue rebalancer: random and directed requests.
`timescale 1ns / 100ps

module tb_top;
   import mqr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   multi_queue_rebalancer_top DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [63:0] lcg;
   logic [15:0] id_store [NUM_QUEUES][QUEUE_DEPTH];
   int          head_ptr [NUM_QUEUES];
   int          tail_ptr [NUM_QUEUES];
   int          fill [NUM_QUEUES];
   logic [15:0] moves;
   logic [3:0]  cfg_queues;
   logic [15:0] cfg_gate_time;
   logic [15:0] cfg_move_limit;

   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   int          errors = 0;
   int          stall_pct = 18;
   bit          hold_sender = 1'b0;
   int          quiet_cycles = 0;

   function automatic int queues_in_use();
      if (cfg_queues == 0) return 1;
      if (cfg_queues > NUM_QUEUES) return NUM_QUEUES;
      return cfg_queues;
   endfunction

   function automatic logic [63:0] wait_of(int q);
      return 64'(fill[q]) * 64'(cfg_gate_time);
   endfunction

   function automatic rsp_type mk(logic [2:0] st, int src, int dst, logic [15:0] who,
                                  logic [63:0] w);
      rsp_type r;
      r.status = st;
      r.source_queue = 3'(src);
      r.target_queue = 3'(dst);
      r.person = who;
      r.wait_time = w[21:0];
      r.switches_done = moves;
      return r;
   endfunction

   function automatic void enqueue_id(int q, logic [15:0] who);
      id_store[q][tail_ptr[q]] = who;
      tail_ptr[q] = (tail_ptr[q] + 1 >= QUEUE_DEPTH) ? 0 : tail_ptr[q] + 1;
      fill[q]++;
   endfunction

   function automatic logic [15:0] dequeue_id(int q);
      logic [15:0] who;
      who = id_store[q][head_ptr[q]];
      head_ptr[q] = (head_ptr[q] + 1 >= QUEUE_DEPTH) ? 0 : head_ptr[q] + 1;
      fill[q]--;
      return who;
   endfunction

   function automatic void predict_queues(req_type r);
      int q, hi, lo;
      logic [63:0] t, tmax, tmin;
      logic [15:0] who;
      case (r.op)
         OP_ARRIVE: begin
            lcg = LCG_MUL * lcg + 64'd1;
            if (lcg == '1) lcg = '0;
            q = int'(lcg[63:32] % 32'(queues_in_use()));
            if (fill[q] >= QUEUE_DEPTH)
               expected_rsps.push_back(mk(ST_FULL, q, 0, 16'd0, wait_of(q)));
            else begin
               enqueue_id(q, r.person_id);
               expected_rsps.push_back(mk(ST_OK, q, 0, r.person_id, wait_of(q)));
            end
         end
         OP_ADMIT: begin
            q = r.gate;
            if (q >= NUM_QUEUES || fill[q] == 0)
               expected_rsps.push_back(mk(ST_EMPTY, q, 0, 16'd0, 64'd0));
            else begin
               who = dequeue_id(q);
               expected_rsps.push_back(mk(ST_OK, q, 0, who, wait_of(q)));
            end
         end
         OP_REBAL: begin
            if (moves >= cfg_move_limit) begin
               expected_rsps.push_back(mk(ST_LIMIT, 0, 0, 16'd0, 64'd0));
            end else begin
               hi = 0; lo = 0;
               tmax = wait_of(0); tmin = tmax;
               for (int i = 1; i < queues_in_use(); i++) begin
                  t = wait_of(i);
                  if (t > tmax) begin tmax = t; hi = i; end
                  if (t < tmin) begin tmin = t; lo = i; end
               end
               if (tmax - tmin <= 64'(cfg_gate_time) || fill[hi] == 0 ||
                   fill[lo] >= QUEUE_DEPTH)
                  expected_rsps.push_back(mk(ST_BALANCED, hi, 0, 16'd0, tmax));
               else begin
                  who = dequeue_id(hi);
                  enqueue_id(lo, who);
                  if (moves < 16'hFFFF) moves++;
                  expected_rsps.push_back(mk(ST_OK, hi, lo, who, wait_of(lo)));
               end
            end
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            predict_queues(req_data);
            void'(pending_reqs.pop_front());
         end
         if ((!start || !busy) && (start && !busy || !start)) begin
            if (pending_reqs.size() > (start && !busy ? 0 : 0) && !hold_sender &&
                $urandom_range(99) >= stall_pct) begin
               start <= 1'b1;
               req_data <= pending_reqs[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data !== e) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   // watchdog: a taken request, a result or a fully idle testbench resets the count
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe ||
          (pending_reqs.size() == 0 && expected_rsps.size() == 0)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_QUEUE_COUNT:  cfg_queues = val[3:0];
         REG_GATE_TIME:    cfg_gate_time = val;
         REG_MAX_SWITCHES: cfg_move_limit = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      int n;
      n = 0;
      while ((pending_reqs.size() != 0 || start || expected_rsps.size() != 0) && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (120) @(posedge clock);
   endtask

   function automatic req_type mk_req(logic [1:0] op, logic [15:0] id, logic [2:0] g);
      req_type r;
      r.op = op; r.person_id = id; r.gate = g;
      return r;
   endfunction

   function automatic req_type rand_req();
      int k;
      k = $urandom_range(99);
      if (k < 50) return mk_req(OP_ARRIVE, 16'($urandom), 3'($urandom));
      if (k < 75) return mk_req(OP_REBAL, 16'($urandom), 3'($urandom));
      if (k < 97) return mk_req(OP_ADMIT, 16'($urandom), 3'($urandom));
      return mk_req(2'd3, 16'($urandom), 3'($urandom));
   endfunction

   initial begin
      lcg = LCG_SEED;
      moves = '0;
      cfg_queues = 4'd8;
      cfg_gate_time = 16'd1;
      cfg_move_limit = SWITCH_RESET;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         head_ptr[q] = 0; tail_ptr[q] = 0; fill[q] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty admits, field extremes, unused op
      pending_reqs.push_back(mk_req(OP_ADMIT, 16'hFFFF, 3'd7));
      pending_reqs.push_back(mk_req(OP_ADMIT, 16'h0000, 3'd0));
      pending_reqs.push_back(mk_req(OP_REBAL, 16'h0000, 3'd0));
      pending_reqs.push_back(mk_req(OP_ARRIVE, 16'h0000, 3'd7));
      pending_reqs.push_back(mk_req(OP_ARRIVE, 16'hFFFF, 3'd0));
      pending_reqs.push_back(mk_req(2'd3, 16'hFFFF, 3'd7));
      pending_reqs.push_back(mk_req(OP_REBAL, 16'h1234, 3'd5));
      pending_reqs.push_back(mk_req(OP_ADMIT, 16'h0, 3'd3));
      drain();

      // single queue: fill past depth to hit full
      write_reg(REG_QUEUE_COUNT, 16'd1);
      write_reg(REG_GATE_TIME, 16'hFFFF);
      for (int i = 0; i < 70; i++) pending_reqs.push_back(mk_req(OP_ARRIVE, 16'(i), 3'd0));
      drain();
      // widen: rebalance spreads the full queue, then limit kicks in
      write_reg(REG_QUEUE_COUNT, 16'd15);
      write_reg(REG_MAX_SWITCHES, 16'd5);
      for (int i = 0; i < 10; i++) pending_reqs.push_back(mk_req(OP_REBAL, 16'd0, 3'd0));
      drain();
      write_reg(REG_QUEUE_COUNT, 16'd0);
      write_reg(REG_MAX_SWITCHES, 16'hFFFF);
      write_reg(REG_GATE_TIME, 16'd0);
      for (int i = 0; i < 6; i++) pending_reqs.push_back(rand_req());
      drain();

      // random phases across settings; one phase with no stalls
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(REG_QUEUE_COUNT, 16'd8); write_reg(REG_GATE_TIME, 16'd1); end
            1: begin write_reg(REG_QUEUE_COUNT, 16'd3); write_reg(REG_GATE_TIME, 16'd37); end
            2: begin stall_pct = 0; write_reg(REG_QUEUE_COUNT, 16'd5); end
            3: begin stall_pct = 18; write_reg(REG_GATE_TIME, 16'hFFFF);
                     write_reg(REG_MAX_SWITCHES, 16'd0); end
            4: begin write_reg(REG_QUEUE_COUNT, 16'd1); write_reg(REG_MAX_SWITCHES, 16'd300);
                     write_reg(REG_GATE_TIME, 16'd2); end
            default: begin write_reg(REG_QUEUE_COUNT, 16'd8);
                           write_reg(REG_MAX_SWITCHES, 16'd10000); end
         endcase
         for (int i = 0; i < 200; i++) begin
            pending_reqs.push_back(rand_req());
            if (ph == 1 && i == 100) begin
               // sender waits until every expected response is back
               while (pending_reqs.size() != 0 || start) @(posedge clock);
               hold_sender = 1'b1;
               while (expected_rsps.size() != 0) @(posedge clock);
               hold_sender = 1'b0;
            end
         end
         drain();
      end

      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
